// ===== rtl/counting_lock_with_wait_queue_core_assert.svh =====
// Assertion macros for the counting lock core.
`ifndef COUNTING_LOCK_WITH_WAIT_QUEUE_CORE_ASSERT_SVH
`define COUNTING_LOCK_WITH_WAIT_QUEUE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clock edge outside reset.
`define CLWQ_ASSERT_NOW(label, cond, expect_expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (expect_expr)) else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define CLWQ_ASSERT_NEXT(label, cond, expect_expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (expect_expr)) else $error(msg);
`else
`define CLWQ_ASSERT_NOW(label, cond, expect_expr, msg)
`define CLWQ_ASSERT_NEXT(label, cond, expect_expr, msg)
`endif
`endif

// ===== rtl/clwq_pkg.sv =====
// Shared types and constants for the counting lock with wait queue.
`default_nettype none
package clwq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int ID_WIDTH     = 8;
   localparam int COUNT_WIDTH  = 8;
   localparam int WCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ID_WIDTH-1:0]     id_type;
   typedef logic [WCOUNT_WIDTH-1:0] wcount_type;
   typedef logic [COUNT_WIDTH-1:0]  hcount_type;

   // Request actions; the last code is not a valid action.
   typedef enum logic [1:0] {
      ACT_LOCK   = 2'd0,
      ACT_UNLOCK = 2'd1,
      ACT_CANCEL = 2'd2,
      ACT_BAD    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_REJECTED  = 3'd2,
      ST_HANDED    = 3'd3,
      ST_RELEASED  = 3'd4,
      ST_CANCELLED = 3'd5,
      ST_ERROR     = 3'd6
   } status_type;

   typedef enum logic [0:0] {
      CSR_MAX_HOLDERS = 1'b0,
      CSR_MAX_WAITERS = 1'b1
   } csr_index_type;

   // One queue entry as it moves between neighboring cells.
   typedef struct packed {
      logic   valid;
      id_type id;
   } entry_type;

   // Command broadcast to every cell of the queue.
   typedef struct packed {
      logic   push;
      logic   pop;
      logic   cancel;
      id_type id;
   } queue_cmd_type;

   // Status gathered from the queue.
   typedef struct packed {
      logic   head_valid;
      id_type head_id;
      logic   found;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== rtl/counting_lock_with_wait_queue_core.sv =====
// Top level of the counting lock with a bounded FIFO wait queue.
// Usage:
//   The req channel carries one lock, unlock or cancel request per accepted
//   item. Every request gives exactly one result on the rsp channel: a status
//   code and, on a hand-over, the id of the woken waiter.
//   The result is registered at the accepting edge and shown on rsp the cycle
//   after. Throughput is one request per cycle while rsp is not stalled; the
//   whole decision, including the cancel search, is combinational along a row
//   of sixteen queue cells whose match chain ripples from head to tail.
//   When rsp is stalled, the registered result holds and req_stall rises, so
//   no further request is taken until the result leaves; a request is still
//   taken in the same cycle that the waiting result is accepted.
//   The csr port sets max_holders and max_waiters; writes take effect at once.
//   The user makes them while no request is in flight; the core does not enforce this.
//   Reset empties the queue, clears the holder count, sets max_holders to one
//   and max_waiters to zero, and drops any pending result.
`default_nettype none
module counting_lock_with_wait_queue_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_requester_id,
   input  wire logic       req_may_wait,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_woken_id,
   output logic            rsp_woken_valid,
   input  wire logic       csr_write_enable,
   input  wire logic [0:0] csr_index,
   input  wire logic [7:0] csr_write_data
);

   logic [7:0]                       max_holders_ff;
   logic [4:0]                       max_waiters_ff;
   clwq_pkg::hcount_type             holder_count_ff, holder_count_in;
   clwq_pkg::wcount_type             waiter_count_ff, waiter_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   clwq_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [7:0]                       rsp_woken_id_ff, rsp_woken_id_in;
   logic                             rsp_woken_valid_ff, rsp_woken_valid_in;

   logic                             req_accept;
   logic                             slot_free;
   clwq_pkg::wcount_type             wait_lim;
   clwq_pkg::queue_cmd_type          cmd;
   clwq_pkg::queue_status_type       qstat;
   logic                             cancel_hit;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign wait_lim = (max_waiters_ff > clwq_pkg::wcount_type'(clwq_pkg::QUEUE_DEPTH))
                     ? clwq_pkg::wcount_type'(clwq_pkg::QUEUE_DEPTH)
                     : clwq_pkg::wcount_type'(max_waiters_ff);

   assign slot_free = holder_count_ff < clwq_pkg::hcount_type'(max_holders_ff);

   clwq_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (qstat)
   );

   assign cancel_hit = cmd.cancel && qstat.found;

   // The queue command is decided from registered counts only, so the cancel
   // search result never feeds back into it.
   always_comb begin
      cmd.push   = 1'b0;
      cmd.pop    = 1'b0;
      cmd.cancel = 1'b0;
      cmd.id     = req_requester_id[clwq_pkg::ID_WIDTH-1:0];
      if (req_accept) begin
         unique case (clwq_pkg::action_type'(req_action))
            clwq_pkg::ACT_LOCK: begin
               cmd.push = !slot_free && req_may_wait && (waiter_count_ff < wait_lim);
            end
            clwq_pkg::ACT_UNLOCK: begin
               cmd.pop = (waiter_count_ff != '0);
            end
            clwq_pkg::ACT_CANCEL: begin
               cmd.cancel = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      holder_count_in    = holder_count_ff;
      waiter_count_in    = waiter_count_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_woken_id_in    = rsp_woken_id_ff;
      rsp_woken_valid_in = rsp_woken_valid_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in       = 1'b1;
         rsp_woken_id_in    = '0;
         rsp_woken_valid_in = 1'b0;
         unique case (clwq_pkg::action_type'(req_action))
            clwq_pkg::ACT_LOCK: begin
               if (slot_free) begin
                  holder_count_in = holder_count_ff + clwq_pkg::hcount_type'(1);
                  rsp_status_in   = clwq_pkg::ST_GRANTED;
               end else if (cmd.push) begin
                  waiter_count_in = waiter_count_ff + clwq_pkg::wcount_type'(1);
                  rsp_status_in   = clwq_pkg::ST_QUEUED;
               end else begin
                  rsp_status_in = clwq_pkg::ST_REJECTED;
               end
            end
            clwq_pkg::ACT_UNLOCK: begin
               if (cmd.pop) begin
                  // The freed slot passes straight to the oldest waiter.
                  waiter_count_in    = waiter_count_ff - clwq_pkg::wcount_type'(1);
                  rsp_status_in      = clwq_pkg::ST_HANDED;
                  rsp_woken_id_in    = 8'(qstat.head_id);
                  rsp_woken_valid_in = 1'b1;
               end else if (holder_count_ff != '0) begin
                  holder_count_in = holder_count_ff - clwq_pkg::hcount_type'(1);
                  rsp_status_in   = clwq_pkg::ST_RELEASED;
               end else begin
                  rsp_status_in = clwq_pkg::ST_ERROR;
               end
            end
            clwq_pkg::ACT_CANCEL: begin
               if (qstat.found) begin
                  waiter_count_in = waiter_count_ff - clwq_pkg::wcount_type'(1);
                  rsp_status_in   = clwq_pkg::ST_CANCELLED;
               end else begin
                  rsp_status_in = clwq_pkg::ST_ERROR;
               end
            end
            default: begin
               rsp_status_in = clwq_pkg::ST_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_holders_ff  <= 8'd1;
         max_waiters_ff  <= 5'd0;
         holder_count_ff <= '0;
         waiter_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (clwq_pkg::csr_index_type'(csr_index))
               clwq_pkg::CSR_MAX_HOLDERS: max_holders_ff <= csr_write_data;
               clwq_pkg::CSR_MAX_WAITERS: max_waiters_ff <= csr_write_data[4:0];
               default: begin
               end
            endcase
         end
         holder_count_ff <= holder_count_in;
         waiter_count_ff <= waiter_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_status_ff      <= rsp_status_in;
      rsp_woken_id_ff    <= rsp_woken_id_in;
      rsp_woken_valid_ff <= rsp_woken_valid_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_woken_id    = rsp_woken_id_ff;
   assign rsp_woken_valid = rsp_woken_valid_ff;

`include "counting_lock_with_wait_queue_core_assert.svh"

   `CLWQ_ASSERT_NOW(a_count_bound, 1'b1,
      waiter_count_ff <= clwq_pkg::wcount_type'(clwq_pkg::QUEUE_DEPTH),
      "waiter count above queue depth")
   `CLWQ_ASSERT_NOW(a_head_matches_count, 1'b1,
      qstat.head_valid == (waiter_count_ff != '0),
      "queue head disagrees with waiter count")
   `CLWQ_ASSERT_NEXT(a_cancel_shrinks, req_accept && cancel_hit,
      waiter_count_ff == $past(waiter_count_ff) - clwq_pkg::wcount_type'(1),
      "cancel did not shrink the queue")
   `CLWQ_ASSERT_NEXT(a_handover_keeps_holders, req_accept && cmd.pop,
      holder_count_ff == $past(holder_count_ff),
      "hand-over changed the holder count")

endmodule
`default_nettype wire

// ===== rtl/clwq_cell.sv =====
// One cell of the wait queue: holds one waiter id and shifts toward the head.
`default_nettype none
module clwq_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire clwq_pkg::queue_cmd_type cmd,
   input  wire logic                    prev_valid,
   input  wire logic                    match_in,
   input  wire clwq_pkg::entry_type     right,
   output clwq_pkg::entry_type          entry,
   output logic                         match_out
);

   logic             valid_ff, valid_in;
   clwq_pkg::id_type id_ff, id_in;
   logic             my_match;
   logic             shift;
   logic             load;

   always_comb begin
      my_match  = valid_ff && cmd.cancel && (id_ff == cmd.id);
      match_out = match_in || my_match;
      // Cells at and behind the oldest matching entry close the gap.
      shift     = cmd.pop || (cmd.cancel && match_out);
      // The first empty cell takes a new waiter.
      load      = cmd.push && !valid_ff && prev_valid;
      valid_in  = valid_ff;
      id_in     = id_ff;
      if (shift) begin
         valid_in = right.valid;
         id_in    = right.id;
      end else if (load) begin
         valid_in = 1'b1;
         id_in    = cmd.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff <= id_in;
   end

   assign entry.valid = valid_ff;
   assign entry.id    = id_ff;

endmodule
`default_nettype wire

// ===== rtl/clwq_chain.sv =====
// Row of queue cells with the head at cell zero and the match chain rippling tailward.
`default_nettype none
module clwq_chain (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire clwq_pkg::queue_cmd_type cmd,
   output clwq_pkg::queue_status_type   status
);

   clwq_pkg::entry_type entries [clwq_pkg::QUEUE_DEPTH];
   clwq_pkg::entry_type rights  [clwq_pkg::QUEUE_DEPTH];
   logic                prevs   [clwq_pkg::QUEUE_DEPTH];
   logic [clwq_pkg::QUEUE_DEPTH:0] match;

   assign match[0] = 1'b0;

   for (genvar g = 0; g < clwq_pkg::QUEUE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prevs[g] = 1'b1;
      end else begin : g_body
         assign prevs[g] = entries[g-1].valid;
      end
      if (g == clwq_pkg::QUEUE_DEPTH - 1) begin : g_tail
         assign rights[g] = '0;
      end else begin : g_inner
         assign rights[g] = entries[g+1];
      end
      clwq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prevs[g]),
         .match_in   (match[g]),
         .right      (rights[g]),
         .entry      (entries[g]),
         .match_out  (match[g+1])
      );
   end

   assign status.head_valid = entries[0].valid;
   assign status.head_id    = entries[0].id;
   assign status.found      = match[clwq_pkg::QUEUE_DEPTH];

endmodule
`default_nettype wire

// ===== bench/counting_lock_with_wait_queue_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the counting lock with wait queue core.
module counting_lock_with_wait_queue_core_tb;

   localparam logic [1:0] ACT_LOCK   = clwq_pkg::ACT_LOCK;
   localparam logic [1:0] ACT_UNLOCK = clwq_pkg::ACT_UNLOCK;
   localparam logic [1:0] ACT_CANCEL = clwq_pkg::ACT_CANCEL;
   localparam logic [1:0] ACT_BAD    = clwq_pkg::ACT_BAD;

   localparam logic [2:0] ST_GRANTED   = clwq_pkg::ST_GRANTED;
   localparam logic [2:0] ST_QUEUED    = clwq_pkg::ST_QUEUED;
   localparam logic [2:0] ST_REJECTED  = clwq_pkg::ST_REJECTED;
   localparam logic [2:0] ST_HANDED    = clwq_pkg::ST_HANDED;
   localparam logic [2:0] ST_RELEASED  = clwq_pkg::ST_RELEASED;
   localparam logic [2:0] ST_CANCELLED = clwq_pkg::ST_CANCELLED;
   localparam logic [2:0] ST_ERROR     = clwq_pkg::ST_ERROR;

   localparam logic [0:0] REG_MAX_HOLDERS = clwq_pkg::CSR_MAX_HOLDERS;
   localparam logic [0:0] REG_MAX_WAITERS = clwq_pkg::CSR_MAX_WAITERS;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 150;
   localparam int N_DIRECTED  = 26;

   typedef struct packed {
      logic [2:0]       status;
      clwq_pkg::id_type woken_id;
      logic             woken_valid;
   } lock_outcome_type;

   typedef struct {
      bit               cfg;       // row writes both limits instead of sending a request
      logic [1:0]       action;
      clwq_pkg::id_type rid;
      logic             may_wait;
      bit               typed;     // outcome below is checked instead of the prediction
      lock_outcome_type outcome;
      logic [7:0]       holders;
      logic [7:0]       waiters;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_action = ACT_LOCK;
   clwq_pkg::id_type req_requester_id = '0;
   logic             req_may_wait = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [2:0]       rsp_status;
   clwq_pkg::id_type rsp_woken_id;
   logic             rsp_woken_valid;
   logic             csr_write_enable = 1'b0;
   logic [0:0]       csr_index = REG_MAX_HOLDERS;
   logic [7:0]       csr_write_data = '0;

   // Shadow of the lock state, advanced once per accepted request.
   clwq_pkg::hcount_type held_count = '0;
   logic [7:0]           holder_limit = 8'd1;
   logic [4:0]           waiter_limit = 5'd0;
   clwq_pkg::id_type     waiting_ids[$];
   lock_outcome_type     pending_outcomes[$];

   int  send_idle_pct = 26;
   int  recv_stall_pct = 64;
   bit  hold_req = 1'b0;
   int  items_sent = 0;
   int  error_count = 0;
   int  cycle_count = 0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b0, 1'b1, {ST_ERROR,    8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_CANCEL, 8'h55, 1'b1, 1'b1, {ST_ERROR,    8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_BAD,    8'hAA, 1'b1, 1'b1, {ST_ERROR,    8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_LOCK,   8'h00, 1'b0, 1'b1, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_LOCK,   8'hFF, 1'b1, 1'b1, {ST_REJECTED, 8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b0, 1'b1, {ST_RELEASED, 8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b1, ACT_LOCK,   8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd1, 8'd31},
      '{1'b0, ACT_LOCK,   8'h3C, 1'b0, 1'b1, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_LOCK,   8'hFF, 1'b1, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_LOCK,   8'h00, 1'b1, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_LOCK,   8'hA5, 1'b0, 1'b1, {ST_REJECTED, 8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_LOCK,   8'hFF, 1'b1, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_CANCEL, 8'hFF, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_CANCEL, 8'h12, 1'b0, 1'b1, {ST_ERROR,    8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_BAD,    8'hFF, 1'b1, 1'b1, {ST_ERROR,    8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b1, ACT_LOCK,   8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd2},
      '{1'b0, ACT_LOCK,   8'h07, 1'b1, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_LOCK,   8'h5A, 1'b0, 1'b1, {ST_REJECTED, 8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b1, ACT_LOCK,   8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd255, 8'd2},
      '{1'b0, ACT_LOCK,   8'h81, 1'b1, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b0, 1'b0, {ST_GRANTED,  8'h00, 1'b0}, 8'd0, 8'd0},
      '{1'b0, ACT_UNLOCK, 8'h00, 1'b1, 1'b1, {ST_ERROR,    8'h00, 1'b0}, 8'd0, 8'd0}
   };

   counting_lock_with_wait_queue_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_requester_id (req_requester_id),
      .req_may_wait     (req_may_wait),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_woken_id     (rsp_woken_id),
      .rsp_woken_valid  (rsp_woken_valid),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Works out the outcome of one lock, unlock or cancel request and advances the shadow.
   function automatic lock_outcome_type predict_outcome(input logic [1:0] act,
                                                        input clwq_pkg::id_type rid,
                                                        input logic mw);
      lock_outcome_type o;
      int wait_cap;
      int pos;
      o = '0;
      wait_cap = (waiter_limit > clwq_pkg::QUEUE_DEPTH) ? clwq_pkg::QUEUE_DEPTH
                                                        : int'(waiter_limit);
      case (act)
         ACT_LOCK: begin
            if (held_count < holder_limit) begin
               held_count++;
               o.status = ST_GRANTED;
            end else if (mw && waiting_ids.size() < wait_cap) begin
               waiting_ids.push_back(rid);
               o.status = ST_QUEUED;
            end else begin
               o.status = ST_REJECTED;
            end
         end
         ACT_UNLOCK: begin
            // The freed slot passes straight to the oldest waiter, if any.
            if (waiting_ids.size() != 0) begin
               o.woken_id = waiting_ids.pop_front();
               o.woken_valid = 1'b1;
               o.status = ST_HANDED;
            end else if (held_count != 0) begin
               held_count--;
               o.status = ST_RELEASED;
            end else begin
               o.status = ST_ERROR;
            end
         end
         ACT_CANCEL: begin
            pos = -1;
            foreach (waiting_ids[k])
               if (pos < 0 && waiting_ids[k] == rid)
                  pos = k;
            if (pos >= 0) begin
               waiting_ids.delete(pos);
               o.status = ST_CANCELLED;
            end else begin
               o.status = ST_ERROR;
            end
         end
         default: o.status = ST_ERROR;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("Mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      lock_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("status of a result with no request outstanding",
                            int'(rsp_status), -1);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_woken_id !== want.woken_id)
               report_mismatch("woken_id", int'(rsp_woken_id), int'(want.woken_id));
            if (rsp_woken_valid !== want.woken_valid)
               report_mismatch("woken_valid", int'(rsp_woken_valid), int'(want.woken_valid));
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_request(input logic [1:0] act, input clwq_pkg::id_type rid,
                               input logic mw, input bit use_typed,
                               input lock_outcome_type typed_outcome);
      lock_outcome_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_requester_id <= rid;
      req_may_wait <= mw;
      do @(posedge clock); while (req_stall);
      predicted = predict_outcome(act, rid, mw);
      pending_outcomes.push_back(use_typed ? typed_outcome : predicted);
      items_sent++;
   endtask

   // Always lets at least one edge pass, so the next drive lands in a later step.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limits(input logic [7:0] holders, input logic [7:0] waiters);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= REG_MAX_HOLDERS;
      csr_write_data <= holders;
      @(posedge clock);
      csr_index <= REG_MAX_WAITERS;
      csr_write_data <= waiters;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      holder_limit = holders;
      waiter_limit = waiters[4:0];
   endtask

   task automatic random_request();
      int               pick;
      clwq_pkg::id_type rid;
      logic             mw;
      logic [1:0]       act;
      pick = $urandom_range(99);
      // A small pool of ids makes duplicates and successful cancels common.
      rid = ($urandom_range(3) == 0) ? clwq_pkg::id_type'($urandom_range(255))
                                     : clwq_pkg::id_type'($urandom_range(7));
      mw = 1'($urandom_range(1));
      if (pick < 42) begin
         act = ACT_LOCK;
         mw = ($urandom_range(9) != 0);
      end else if (pick < 72) begin
         act = ACT_UNLOCK;
      end else if (pick < 96) begin
         act = ACT_CANCEL;
         if (waiting_ids.size() != 0 && $urandom_range(4) != 0)
            rid = waiting_ids[$urandom_range(waiting_ids.size() - 1)];
      end else begin
         act = ACT_BAD;
      end
      send_request(act, rid, mw, 1'b0, '0);
   endtask

   // Sends lock requests that may fill the holder slots and the queue, then as many unlocks to empty them.
   task automatic fill_and_empty();
      int n;
      n = $urandom_range(8, 20);
      repeat (n) send_request(ACT_LOCK, clwq_pkg::id_type'($urandom_range(255)),
                              ($urandom_range(7) != 0), 1'b0, '0);
      repeat (n) send_request(ACT_UNLOCK, clwq_pkg::id_type'($urandom_range(255)),
                              1'($urandom_range(1)), 1'b0, '0);
   endtask

   task automatic run_segment(input int n_items);
      int stop_at;
      int pick;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 6)
            fill_and_empty();
         else if (pick < 8)
            drain_results();
         else
            random_request();
      end
   endtask

   task automatic random_limits();
      logic [7:0] holders;
      logic [7:0] waiters;
      case ($urandom_range(7))
         0: holders = 8'd0;
         1: holders = 8'd255;
         2: holders = 8'd1;
         3: holders = 8'd2;
         default: holders = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(5))
         0: waiters = 8'd0;
         1: waiters = 8'd31;
         2: waiters = 8'd16;
         3: waiters = 8'($urandom_range(17, 30));
         default: waiters = 8'($urandom_range(1, 15));
      endcase
      write_limits(holders, waiters);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].cfg)
            write_limits(directed_rows[i].holders, directed_rows[i].waiters);
         else
            send_request(directed_rows[i].action, directed_rows[i].rid,
                         directed_rows[i].may_wait, directed_rows[i].typed,
                         directed_rows[i].outcome);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               recv_stall_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_stall_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            random_limits();
            // The receiver holds off while requests keep coming, so the core backs up.
            if (phase == 0 && seg == 1)
               hold_req = 1'b1;
            run_segment(50);
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
